// File: sv/prfl_pkg.sv
// ----------------------------------------------------------------------------
// prfl_pkg
// Shared sizes, register indexes and types of the page replacement unit.
// ----------------------------------------------------------------------------
package prfl_pkg;

  localparam int FRAMES    = 8;
  localparam int ADDR_BITS = 32;

  localparam int FRAME_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W      = $clog2(FRAMES + 1);
  localparam int FIDX_W     = 3;
  localparam int FAULT_W    = 32;
  localparam int PSHIFT_W   = 5;
  localparam int MSHIFT_W   = 6;
  localparam int FIU_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SHIFT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd3;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef struct packed {
    logic [PSHIFT_W-1:0] page_shift;
    logic [MSHIFT_W-1:0] mem_shift;
    logic                policy;
    logic [CNT_W-1:0]    frames;     // clamped to 1..FRAMES
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] page;
    logic [FRAME_W-1:0]   rank;
  } entry_t;

  typedef struct packed {
    logic                 en;
    logic [FRAME_W-1:0]   idx;
    logic                 was_valid;
    logic [ADDR_BITS-1:0] page;
  } upd_t;

endpackage

// File: sv/prfl_frame_table.sv
// ----------------------------------------------------------------------------
// prfl_frame_table
// Frame store: page per frame, valid bits and LRU age ranks, one read port
// and one touch/load port.
// ----------------------------------------------------------------------------
module prfl_frame_table import prfl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [FRAME_W-1:0] rd_idx_i,
  output entry_t             rd_o,
  input  upd_t               upd_i
);

  logic [FRAMES-1:0]    valid_q;
  logic [FRAME_W-1:0]   rank_q [FRAMES];
  logic [ADDR_BITS-1:0] page_q [FRAMES];

  assign rd_o.valid = valid_q[rd_idx_i];
  assign rd_o.page  = page_q[rd_idx_i];
  assign rd_o.rank  = rank_q[rd_idx_i];

  // Touch: age the frames that were younger than the touched one (all valid
  // ones on a fresh load), then make the touched one the youngest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int k = 0; k < FRAMES; k++) begin
        rank_q[k] <= '0;
      end
    end else if (upd_i.en) begin
      for (int k = 0; k < FRAMES; k++) begin
        if (FRAME_W'(k) == upd_i.idx) begin
          rank_q[k]  <= '0;
          valid_q[k] <= 1'b1;
        end else if (valid_q[k] &&
                     (!upd_i.was_valid || rank_q[k] < rank_q[upd_i.idx])) begin
          rank_q[k] <= rank_q[k] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en) begin
      page_q[upd_i.idx] <= upd_i.page;
    end
  end

endmodule

// File: sv/prfl_seq.sv
// ----------------------------------------------------------------------------
// prfl_seq
// Sequencer: range check, one-frame-per-cycle scan through the shared page
// comparator, victim choice, fault count and result register.
// ----------------------------------------------------------------------------
module prfl_seq import prfl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ADDR_BITS-1:0] virtual_address_i,
  output logic [FRAME_W-1:0]   rd_idx_o,
  input  entry_t               rd_i,
  output upd_t                 upd_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 fault_o,
  output logic                 range_error_o,
  output logic [FIDX_W-1:0]    frame_index_o,
  output logic [FAULT_W-1:0]   fault_total_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [ADDR_BITS-1:0] page_q;
  logic [FRAME_W-1:0]   idx_q, hit_q, empty_q, lru_q, best_q, fifo_q, fifo_eff;
  logic                 found_q, empty_found_q;
  logic [FAULT_W-1:0]   count_q;
  logic                 res_fault_q, res_range_q;
  logic [FRAME_W-1:0]   res_frame_q;
  logic                 out_valid_q;
  logic                 accept, out_free, scan_last, page_hit;
  logic                 range_err;
  logic [FRAME_W-1:0]   victim;
  logic                 fifo_evict;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign range_err  = (virtual_address_i >> cfg_i.mem_shift) != '0;
  assign scan_last  = (CNT_W'(idx_q) + 1'b1) == cfg_i.frames;
  assign page_hit   = rd_i.valid && (rd_i.page == page_q);
  assign rd_idx_o   = idx_q;

  // A stale pointer past the frame count wraps before use.
  assign fifo_eff = (CNT_W'(fifo_q) >= cfg_i.frames) ? '0 : fifo_q;

  always_comb begin
    fifo_evict = 1'b0;
    if (found_q) begin
      victim = hit_q;
    end else if (empty_found_q) begin
      victim = empty_q;
    end else if (cfg_i.policy == POLICY_FIFO) begin
      victim     = fifo_eff;
      fifo_evict = 1'b1;
    end else begin
      victim = lru_q;
    end
  end

  assign upd_o.en        = (state_q == S_UPD);
  assign upd_o.idx       = victim;
  assign upd_o.was_valid = found_q || !empty_found_q;
  assign upd_o.page      = page_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = range_err ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_UPD;
        end
      end
      S_UPD:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fifo_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_UPD && !found_q) begin
        if (count_q != '1) begin
          count_q <= count_q + 1'b1;
        end
        if (fifo_evict) begin
          fifo_q <= (CNT_W'(fifo_eff) + 1'b1 >= cfg_i.frames) ? '0 : fifo_eff + 1'b1;
        end
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Work registers and result payload.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          page_q        <= virtual_address_i >> cfg_i.page_shift;
          idx_q         <= '0;
          found_q       <= 1'b0;
          empty_found_q <= 1'b0;
          best_q        <= '0;
          lru_q         <= '0;
          hit_q         <= '0;
          empty_q       <= '0;
          res_fault_q   <= 1'b0;
          res_range_q   <= range_err;
          res_frame_q   <= '0;
        end
      end
      S_SCAN: begin
        if (page_hit && !found_q) begin
          found_q <= 1'b1;
          hit_q   <= idx_q;
        end
        if (!rd_i.valid && !empty_found_q) begin
          empty_found_q <= 1'b1;
          empty_q       <= idx_q;
        end
        if (rd_i.rank >= best_q) begin
          best_q <= rd_i.rank;
          lru_q  <= idx_q;
        end
        if (!scan_last) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      S_UPD: begin
        res_fault_q <= !found_q;
        res_frame_q <= victim;
      end
      S_DONE: begin
        if (out_free) begin
          fault_o       <= res_fault_q;
          range_error_o <= res_range_q;
          frame_index_o <= FIDX_W'(res_frame_q);
          fault_total_o <= count_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/page_replacement_fifo_lru_unit.sv
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_unit
// FIFO / LRU page replacement: looks each virtual address up among the
// frames in use, counts faults and picks a victim frame on a miss.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  ------    ---------               -------
//  in        in_valid_i / in_stall_o virtual_address_i
//  out       out_valid_o/ out_stall_i fault_o, range_error_o, frame_index_o,
//                                    fault_total_o
//  cfg       cfg_we_i                cfg_index_i, cfg_data_i
//
// For a mapped address, the scan reads one frame per cycle through a single
// page comparator. A range error skips the scan.
// One item is in work at a time; the next is taken once the current one
// has moved into the output register, even while that result is stalled.
// Reset clears valid bits, ranks, FIFO pointer and fault count at once.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_unit import prfl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADDR_BITS-1:0]  virtual_address_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  fault_o,
  output logic                  range_error_o,
  output logic [FIDX_W-1:0]     frame_index_o,
  output logic [FAULT_W-1:0]    fault_total_o
);

  logic [PSHIFT_W-1:0] page_shift_q;
  logic [MSHIFT_W-1:0] mem_shift_q;
  logic                policy_q;
  logic [FIU_W-1:0]    frames_in_use_q;
  cfg_t                cfg;
  logic [FRAME_W-1:0]  rd_idx;
  entry_t              rd_entry;
  upd_t                upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q    <= PSHIFT_W'(10);
      mem_shift_q     <= MSHIFT_W'(16);
      policy_q        <= POLICY_LRU;
      frames_in_use_q <= FIU_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PAGE_SHIFT:    page_shift_q    <= cfg_data_i[PSHIFT_W-1:0];
        CFG_MEM_SHIFT:     mem_shift_q     <= cfg_data_i[MSHIFT_W-1:0];
        CFG_POLICY:        policy_q        <= cfg_data_i[0];
        CFG_FRAMES_IN_USE: frames_in_use_q <= cfg_data_i[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame count to 1..FRAMES.
  always_comb begin
    cfg.page_shift = page_shift_q;
    cfg.mem_shift  = mem_shift_q;
    cfg.policy     = policy_q;
    if (frames_in_use_q == '0) begin
      cfg.frames = CNT_W'(1);
    end else if (int'(frames_in_use_q) > FRAMES) begin
      cfg.frames = CNT_W'(FRAMES);
    end else begin
      cfg.frames = CNT_W'(frames_in_use_q);
    end
  end

  prfl_frame_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd_entry),
    .upd_i    (upd)
  );

  prfl_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .virtual_address_i (virtual_address_i),
    .rd_idx_o          (rd_idx),
    .rd_i              (rd_entry),
    .upd_o             (upd),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .fault_o           (fault_o),
    .range_error_o     (range_error_o),
    .frame_index_o     (frame_index_o),
    .fault_total_o     (fault_total_o)
  );

endmodule

// File: bench/page_replacement_fifo_lru_unit_scoreboard.sv
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_unit_scoreboard
// Watches the configuration port and both channels of the page replacement
// unit. Keeps its own frame table, age ranks, FIFO pointer and fault count,
// works out the translation of every accepted address, and compares each
// result beat with the oldest pending translation.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_unit_scoreboard import prfl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [ADDR_BITS-1:0]  virtual_address_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  fault_i,
  input  logic                  range_error_i,
  input  logic [FIDX_W-1:0]     frame_index_i,
  input  logic [FAULT_W-1:0]    fault_total_i,
  output int                    errors_o,
  output int                    pending_o
);

  typedef struct packed {
    logic                 fault;
    logic                 range_error;
    logic [FIDX_W-1:0]    frame_index;
    logic [FAULT_W-1:0]   fault_total;
  } xlate_result_t;

  xlate_result_t        pending_xlate_q[$];

  logic [PSHIFT_W-1:0]  page_shift_q;
  logic [MSHIFT_W-1:0]  mem_shift_q;
  logic                 policy_q;
  logic [FIU_W-1:0]     frames_q;

  logic [ADDR_BITS-1:0] held_page [FRAMES];
  logic                 held_valid [FRAMES];
  int                   age_rank [FRAMES];
  int                   evict_ptr;
  logic [FAULT_W-1:0]   fault_count;
  int                   fail_count;

  // Make frame f the most recent; only frames younger than it age when it
  // was already loaded, all loaded frames age when it is freshly filled.
  task automatic promote_frame(input int f, input logic was_valid);
    int old;
    old = age_rank[f];
    for (int k = 0; k < FRAMES; k++) begin
      if (k != f && held_valid[k] && (!was_valid || age_rank[k] < old)) begin
        age_rank[k]++;
      end
    end
    age_rank[f] = 0;
  endtask

  task automatic translate_address(input logic [ADDR_BITS-1:0] addr,
                                   output xlate_result_t res);
    int                   n;
    int                   victim;
    int                   best;
    logic                 found;
    logic                 empty;
    logic [ADDR_BITS-1:0] page;
    res = '0;
    res.fault_total = fault_count;
    // Shifts of 32 or more leave nothing, so a huge memory never overflows.
    if ((addr >> mem_shift_q) != '0) begin
      res.range_error = 1'b1;
      return;
    end
    n = (frames_q == 0) ? 1 : (frames_q > FRAMES) ? FRAMES : int'(frames_q);
    page = addr >> page_shift_q;
    found = 1'b0;
    victim = 0;
    for (int j = 0; j < n; j++) begin
      if (!found && held_valid[j] && held_page[j] == page) begin
        found = 1'b1;
        victim = j;
      end
    end
    if (found) begin
      promote_frame(victim, 1'b1);
      res.frame_index = victim[FIDX_W-1:0];
      return;
    end
    if (fault_count != '1) begin
      fault_count++;
    end
    empty = 1'b0;
    for (int j = 0; j < n; j++) begin
      if (!empty && !held_valid[j]) begin
        empty = 1'b1;
        victim = j;
      end
    end
    if (empty) begin
      promote_frame(victim, 1'b0);
      held_valid[victim] = 1'b1;
    end else if (policy_q == POLICY_FIFO) begin
      // wrap a pointer left stale by a smaller frame count
      if (evict_ptr >= n) begin
        evict_ptr = 0;
      end
      victim = evict_ptr;
      evict_ptr = (evict_ptr + 1 >= n) ? 0 : evict_ptr + 1;
      promote_frame(victim, 1'b1);
    end else begin
      best = 0;
      victim = 0;
      for (int j = 0; j < n; j++) begin
        if (age_rank[j] >= best) begin
          best = age_rank[j];
          victim = j;
        end
      end
      promote_frame(victim, 1'b1);
    end
    held_page[victim] = page;
    res.fault = 1'b1;
    res.frame_index = victim[FIDX_W-1:0];
    res.fault_total = fault_count;
  endtask

  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    xlate_result_t want;
    if (!rst_ni) begin
      pending_xlate_q.delete();
      page_shift_q = 5'd10;
      mem_shift_q  = 6'd16;
      policy_q     = POLICY_LRU;
      frames_q     = 4'd8;
      for (int k = 0; k < FRAMES; k++) begin
        held_page[k]  = '0;
        held_valid[k] = 1'b0;
        age_rank[k]   = 0;
      end
      evict_ptr   = 0;
      fault_count = '0;
      fail_count  = 0;
    end else begin
      // check the result beat before queuing this edge's address
      if (out_valid_i && !out_stall_i) begin
        if (pending_xlate_q.size() == 0) begin
          $error("result beat with no translation pending");
          fail_count++;
        end else begin
          want = pending_xlate_q.pop_front();
          fail_count += field_differs("fault", want.fault, fault_i);
          fail_count += field_differs("range_error", want.range_error, range_error_i);
          fail_count += field_differs("frame_index", want.frame_index, frame_index_i);
          fail_count += field_differs("fault_total", want.fault_total, fault_total_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PAGE_SHIFT:    page_shift_q = cfg_data_i[PSHIFT_W-1:0];
          CFG_MEM_SHIFT:     mem_shift_q  = cfg_data_i[MSHIFT_W-1:0];
          CFG_POLICY:        policy_q     = cfg_data_i[0];
          CFG_FRAMES_IN_USE: frames_q     = cfg_data_i[FIU_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        translate_address(virtual_address_i, want);
        pending_xlate_q.push_back(want);
      end
    end
    errors_o  <= fail_count;
    pending_o <= pending_xlate_q.size();
  end

endmodule

// File: bench/page_replacement_fifo_lru_unit_test.sv
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_unit_test
// Drives the page replacement unit with directed references (range limits,
// fills, hits, FIFO and LRU evictions, odd frame counts and shifts), then
// with random references drawn mostly from a small page pool so that hits
// and evictions are frequent, across several settings and idle patterns.
// The scoreboard beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_unit_test;
  import prfl_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [ADDR_BITS-1:0]  virtual_address_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  fault_o;
  logic                  range_error_o;
  logic [FIDX_W-1:0]     frame_index_o;
  logic [FAULT_W-1:0]    fault_total_o;

  int mismatch_count;
  int results_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  logic [PSHIFT_W-1:0]  cur_page_shift = 5'd10;
  logic [MSHIFT_W-1:0]  cur_mem_shift = 6'd16;
  logic [ADDR_BITS-1:0] pool_base = '0;
  int                   pool_size = FRAMES + 3;

  page_replacement_fifo_lru_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .virtual_address_i (virtual_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .fault_o           (fault_o),
    .range_error_o     (range_error_o),
    .frame_index_o     (frame_index_o),
    .fault_total_o     (fault_total_o)
  );

  page_replacement_fifo_lru_unit_scoreboard u_scoreboard (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .virtual_address_i (virtual_address_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .fault_i           (fault_o),
    .range_error_i     (range_error_o),
    .frame_index_i     (frame_index_o),
    .fault_total_i     (fault_total_o),
    .errors_o          (mismatch_count),
    .pending_o         (results_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("page_replacement_fifo_lru_unit test failed");
      $finish;
    end
  end

  // Result side: random stall, or a long hold-off when one is requested.
  always begin
    @(negedge clk_i);
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 83;
        recv_stall_pct <= 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct <= 83;
      end
      default: begin
        send_idle_pct = 8;
        recv_stall_pct <= 8;
      end
    endcase
  endtask

  // Offer one address; return at the edge that accepts the beat.
  task automatic send_address(input logic [ADDR_BITS-1:0] addr);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    virtual_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
  endtask

  // Reprogram all registers once the block has gone quiet. Unused upper
  // data bits get random values; the block must ignore them.
  task automatic set_config(input int ps, input int ms, input logic pol, input int fr);
    int n;
    wait_for_results();
    repeat (16) @(negedge clk_i);
    write_reg(CFG_PAGE_SHIFT, {1'($urandom_range(0, 1)), 5'(ps)});
    write_reg(CFG_MEM_SHIFT, 6'(ms));
    write_reg(CFG_POLICY, {5'($urandom_range(0, 31)), pol});
    write_reg(CFG_FRAMES_IN_USE, {2'($urandom_range(0, 3)), 4'(fr)});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_page_shift = 5'(ps);
    cur_mem_shift = 6'(ms);
    n = (4'(fr) == 0) ? 1 : (4'(fr) > FRAMES) ? FRAMES : int'(4'(fr));
    pool_size = n + 3;
    pool_base = $urandom;
  endtask

  // Mostly pages from a small pool, plus random in-range, out-of-range and
  // fully random addresses.
  function automatic logic [ADDR_BITS-1:0] pick_address();
    logic [63:0] mem_mask;
    logic [63:0] max_page;
    logic [63:0] off_mask;
    logic [63:0] pg;
    logic [63:0] a;
    int          roll;
    mem_mask = (cur_mem_shift >= 32) ? 64'hFFFF_FFFF : ((64'd1 << cur_mem_shift) - 1);
    max_page = mem_mask >> cur_page_shift;
    off_mask = (64'd1 << cur_page_shift) - 1;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      pg = 64'(pool_base) + 64'($urandom_range(0, pool_size - 1));
      pg = pg % (max_page + 1);
      a = ((pg << cur_page_shift) | (64'($urandom) & off_mask)) & mem_mask;
    end else if (roll < 80) begin
      a = 64'($urandom) & mem_mask;
    end else if (roll < 90 && cur_mem_shift < 32) begin
      a = 64'($urandom | (32'd1 << $urandom_range(cur_mem_shift, 31)));
    end else begin
      a = 64'($urandom);
    end
    return a[ADDR_BITS-1:0];
  endfunction

  task automatic run_phase(input idle_mode_e mode, input int count, input bit hold,
                           input bit pause_mid);
    set_idle(mode);
    if (hold) begin
      hold_seq <= hold_seq + 1;
    end
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) begin
        wait_for_results();
      end
      send_address(pick_address());
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: 1 KiB pages, 64 KiB memory, LRU, all frames.
    set_idle(IDLE_NONE);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0001_0000);
    send_address(32'h0000_FFFF);
    send_address(32'h0000_03FF);
    for (int p = 1; p <= 7; p++) begin
      send_address(ADDR_BITS'(p) << 10);
    end

    set_config(10, 16, POLICY_FIFO, 8);
    send_address(ADDR_BITS'(8) << 10);
    send_address(ADDR_BITS'(9) << 10);
    // pointer now past the frame count; page 5 sits beyond it
    set_config(10, 16, POLICY_FIFO, 2);
    send_address(ADDR_BITS'(10) << 10);
    send_address(ADDR_BITS'(5) << 10);
    set_config(10, 16, POLICY_LRU, 0);
    send_address(ADDR_BITS'(11) << 10);
    send_address(ADDR_BITS'(11) << 10);
    set_config(10, 16, POLICY_LRU, 15);
    send_address(ADDR_BITS'(5) << 10);
    // page bigger than memory, memory bigger than the address space
    set_config(31, 32, POLICY_FIFO, 8);
    send_address(32'hFFFF_FFFF);
    send_address(32'h1234_5678);
    set_config(0, 0, POLICY_LRU, 8);
    send_address(32'h0000_0000);
    send_address(32'h0000_0001);
    set_config(0, 63, POLICY_LRU, 8);
    send_address(32'h8000_0000);

    set_config(10, 16, POLICY_LRU, 8);
    run_phase(IDLE_NONE, 50, 1'b0, 1'b0);
    set_config(4, 12, POLICY_FIFO, 5);
    run_phase(IDLE_SEND, 50, 1'b0, 1'b0);
    set_config(0, 32, POLICY_LRU, 3);
    run_phase(IDLE_RECV, 50, 1'b0, 1'b1);
    set_config(31, 20, POLICY_FIFO, 8);
    run_phase(IDLE_BOTH, 30, 1'b0, 1'b0);
    set_config(12, 63, POLICY_FIFO, 0);
    run_phase(IDLE_NONE, 40, 1'b0, 1'b0);
    set_config(6, 14, POLICY_LRU, 15);
    run_phase(IDLE_SEND, 50, 1'b0, 1'b0);
    // hold the result side off so the block backs up into its input
    set_config(8, 18, POLICY_FIFO, 8);
    run_phase(IDLE_NONE, 40, 1'b1, 1'b0);
    set_config(3, 9, POLICY_FIFO, 1);
    run_phase(IDLE_BOTH, 30, 1'b0, 1'b0);
    for (int r = 0; r < 2; r++) begin
      set_config($urandom_range(0, 31), $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 15));
      run_phase(idle_mode_e'($urandom_range(0, 3)), 30, 1'b0, 1'b0);
    end

    wait_for_results();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("page_replacement_fifo_lru_unit test passed");
    end else begin
      $display("page_replacement_fifo_lru_unit test failed");
    end
    $finish;
  end

endmodule

// File: page_replacement_fifo_lru_unit.f
sv/prfl_pkg.sv
sv/prfl_frame_table.sv
sv/prfl_seq.sv
sv/page_replacement_fifo_lru_unit.sv
bench/page_replacement_fifo_lru_unit_scoreboard.sv
bench/page_replacement_fifo_lru_unit_test.sv
